// ----- src/tpsr_pkg.sv -----
`default_nettype none

package tpsr_pkg;

    // Default widths of the coordinate readings and of the calibration registers.
    localparam int COORD_BITS_DEF = 12;
    localparam int COEF_BITS_DEF  = 16;

    // Calibrated outputs are always 16-bit signed.
    localparam int CAL_BITS = 16;

    // Serial frame: one command byte out, sixteen bits in.
    localparam int CMD_BITS     = 8;
    localparam int RX_BITS      = 16;
    localparam int BIT_CNT_BITS = 5;

    // Converter command bytes for the two axes.
    localparam logic [CMD_BITS-1:0] CMD_X = 8'h94;
    localparam logic [CMD_BITS-1:0] CMD_Y = 8'hD4;

    // Configuration register indexes.
    localparam int CFG_IDX_BITS = 2;
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SCALE_X  = 2'd0,
        CFG_OFFSET_X = 2'd1,
        CFG_SCALE_Y  = 2'd2,
        CFG_OFFSET_Y = 2'd3
    } t_cfg_idx;

    // Serial sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_SELECT = 3'd1,
        ST_CMD    = 3'd2,
        ST_RECV   = 3'd3,
        ST_DONE   = 3'd4
    } t_seq_state;

endpackage

`default_nettype wire

// ----- src/tpsr_in_if.sv -----
`default_nettype none

// One serial tick request: start request, pen line and converter data bit.
interface tpsr_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic pen_irq_n;
    logic miso;

    modport source (output valid, output start_req, output pen_irq_n, output miso,
                    input ready);
    modport sink (input valid, input start_req, input pen_irq_n, input miso,
                  output ready);
endinterface

`default_nettype wire

// ----- src/tpsr_out_if.sv -----
`default_nettype none

// One result request per tick: pin levels, status and held readings.
interface tpsr_out_if #(
    parameter int COORD_BITS = tpsr_pkg::COORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                cs_n;
    logic                                sck;
    logic                                mosi;
    logic                                busy_res;
    logic                                sample_valid;
    logic        [COORD_BITS-1:0]        raw_x;
    logic        [COORD_BITS-1:0]        raw_y;
    logic signed [tpsr_pkg::CAL_BITS-1:0] cal_x;
    logic signed [tpsr_pkg::CAL_BITS-1:0] cal_y;
    logic                                coef_bad;
    logic                                pen_down;

    modport source (output valid, output cs_n, output sck, output mosi, output busy_res,
                    output sample_valid, output raw_x, output raw_y, output cal_x,
                    output cal_y, output coef_bad, output pen_down, input ready);
    modport sink (input valid, input cs_n, input sck, input mosi, input busy_res,
                  input sample_valid, input raw_x, input raw_y, input cal_x,
                  input cal_y, input coef_bad, input pen_down, output ready);
endinterface

`default_nettype wire

// ----- src/touch_panel_serial_reader_unit.sv -----
`default_nettype none

// Channel   Direction  Handshake          Payload
// i_tick    in         valid / ready      start_req, pen_irq_n, miso
// o_res     out        valid / ready      cs_n, sck, mosi, busy_res, sample_valid,
//                                         raw_x, raw_y, cal_x, cal_y, coef_bad, pen_down
// i_cfg_*   in         write enable only  register index, register data
//
// Every tick request yields one result request. The result sits in an output register,
// and a new tick is taken in the cycle the old result leaves. The tick that finishes
// the Y axis with good coefficients runs the shared bit-serial divider for X and then
// Y. Reset is synchronous and active low; no tick is taken while the divider runs.

module touch_panel_serial_reader_unit #(
    parameter int COORD_BITS = tpsr_pkg::COORD_BITS_DEF,
    parameter int COEF_BITS  = tpsr_pkg::COEF_BITS_DEF
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_cfg_we,
    input  wire  [tpsr_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  wire  [COEF_BITS-1:0]                  i_cfg_data,
    tpsr_in_if.sink                               i_tick,
    tpsr_out_if.source                            o_res
);

    localparam int CAL_BITS = tpsr_pkg::CAL_BITS;
    localparam int RX_BITS  = tpsr_pkg::RX_BITS;
    localparam int BCW      = tpsr_pkg::BIT_CNT_BITS;
    localparam int DIV_CW   = $clog2(COORD_BITS + 1);
    localparam int SUM_W0   = (COORD_BITS + 1 > COEF_BITS) ? COORD_BITS + 1 : COEF_BITS;
    localparam int SUM_W    = ((SUM_W0 > CAL_BITS) ? SUM_W0 : CAL_BITS) + 1;

    // Configuration registers.
    logic [COEF_BITS-1:0] r_scale_x;
    logic [COEF_BITS-1:0] r_offset_x;
    logic [COEF_BITS-1:0] r_scale_y;
    logic [COEF_BITS-1:0] r_offset_y;

    // Sequencer state.
    tpsr_pkg::t_seq_state r_state, n_state;
    logic                 r_axis, n_axis;
    logic [BCW-1:0]       r_bit_cnt, n_bit_cnt;
    logic                 r_clk_lvl, n_clk_lvl;
    logic [RX_BITS-1:0]   r_shift, n_shift;
    logic [COORD_BITS-1:0] r_raw_x, n_raw_x;
    logic [COORD_BITS-1:0] r_raw_y, n_raw_y;
    logic [CAL_BITS-1:0]  r_cal_x;
    logic [CAL_BITS-1:0]  r_cal_y;

    // Output register.
    logic r_out_vld;
    logic r_o_cs_n, r_o_sck, r_o_mosi, r_o_busy, r_o_sv, r_o_pen;

    // Divider.
    logic                  r_div_run;
    logic                  r_div_axis;
    logic [DIV_CW-1:0]     r_div_cnt;
    logic [COEF_BITS-1:0]  r_rem;
    logic [COORD_BITS-1:0] r_dvd;

    logic                  w_accept;
    logic                  w_coef_bad;
    logic                  w_cal_start;
    logic                  w_cs_n, w_sck, w_mosi, w_busy, w_sv;
    logic [BCW-1:0]        w_bit_inc;
    logic [RX_BITS-1:0]    w_shift_in;
    logic [tpsr_pkg::CMD_BITS-1:0] w_cmd;

    logic [COEF_BITS-1:0]  w_scale_sel;
    logic [COEF_BITS-1:0]  w_offset_sel;
    logic [COEF_BITS-1:0]  w_mag;
    logic [COEF_BITS:0]    w_trial;
    logic [COEF_BITS:0]    w_diff;
    logic [SUM_W-1:0]      w_q_ext;
    logic [SUM_W-1:0]      w_q_sgn;
    logic [SUM_W-1:0]      w_sum;
    logic                  w_fits;
    logic [CAL_BITS-1:0]   w_sat;
    logic                  w_div_done;

    // Handshakes.
    assign i_tick.ready = !r_div_run && (!r_out_vld || o_res.ready);
    assign w_accept     = i_tick.valid && i_tick.ready;

    // A zero scale or any all-ones register disables calibration.
    assign w_coef_bad = ~(|r_scale_x) || ~(|r_scale_y) || (&r_scale_x) || (&r_offset_x)
                        || (&r_scale_y) || (&r_offset_y);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x  <= COEF_BITS'(1);
            r_offset_x <= '0;
            r_scale_y  <= COEF_BITS'(1);
            r_offset_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tpsr_pkg::CFG_SCALE_X:  r_scale_x  <= i_cfg_data;
                tpsr_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data;
                tpsr_pkg::CFG_SCALE_Y:  r_scale_y  <= i_cfg_data;
                tpsr_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_bit_inc  = r_bit_cnt + BCW'(1);
    assign w_shift_in = {r_shift[RX_BITS-2:0], i_tick.miso};
    assign w_cmd      = r_axis ? tpsr_pkg::CMD_Y : tpsr_pkg::CMD_X;

    // Next state of the sequencer for one tick.
    always_comb begin
        n_state     = r_state;
        n_axis      = r_axis;
        n_bit_cnt   = r_bit_cnt;
        n_clk_lvl   = r_clk_lvl;
        n_shift     = r_shift;
        n_raw_x     = r_raw_x;
        n_raw_y     = r_raw_y;
        w_cal_start = 1'b0;
        case (r_state)
            tpsr_pkg::ST_SELECT: begin
                if (i_tick.pen_irq_n) begin
                    // Pen up: this axis reads all ones.
                    if (r_axis) begin
                        n_raw_y = '1;
                    end else begin
                        n_raw_x = '1;
                    end
                    n_state = tpsr_pkg::ST_DONE;
                end else begin
                    n_bit_cnt = '0;
                    n_clk_lvl = 1'b0;
                    n_state   = tpsr_pkg::ST_CMD;
                end
            end
            tpsr_pkg::ST_CMD: begin
                n_clk_lvl = !r_clk_lvl;
                if (r_clk_lvl) begin
                    n_bit_cnt = w_bit_inc;
                    if (w_bit_inc >= BCW'(tpsr_pkg::CMD_BITS)) begin
                        n_bit_cnt = '0;
                        n_shift   = '0;
                        n_state   = tpsr_pkg::ST_RECV;
                    end
                end
            end
            tpsr_pkg::ST_RECV: begin
                n_clk_lvl = !r_clk_lvl;
                if (r_clk_lvl) begin
                    n_shift   = w_shift_in;
                    n_bit_cnt = w_bit_inc;
                    if (w_bit_inc >= BCW'(RX_BITS)) begin
                        n_bit_cnt = '0;
                        if (r_axis) begin
                            n_raw_y = w_shift_in[RX_BITS-1 -: COORD_BITS];
                        end else begin
                            n_raw_x = w_shift_in[RX_BITS-1 -: COORD_BITS];
                        end
                        n_state = tpsr_pkg::ST_DONE;
                    end
                end
            end
            tpsr_pkg::ST_DONE: begin
                if (!r_axis) begin
                    n_axis  = 1'b1;
                    n_state = tpsr_pkg::ST_SELECT;
                end else begin
                    n_axis      = 1'b0;
                    n_state     = tpsr_pkg::ST_IDLE;
                    w_cal_start = !w_coef_bad;
                end
            end
            default: begin
                n_state = tpsr_pkg::ST_IDLE;
                if (i_tick.start_req) begin
                    n_axis    = 1'b0;
                    n_bit_cnt = '0;
                    n_clk_lvl = 1'b0;
                    n_state   = tpsr_pkg::ST_SELECT;
                end
            end
        endcase
    end

    // Pin levels and status for one tick.
    always_comb begin
        w_cs_n = 1'b1;
        w_sck  = 1'b0;
        w_mosi = 1'b0;
        w_busy = 1'b1;
        w_sv   = 1'b0;
        case (r_state)
            tpsr_pkg::ST_SELECT: begin
                w_cs_n = i_tick.pen_irq_n;
            end
            tpsr_pkg::ST_CMD: begin
                w_cs_n = 1'b0;
                w_sck  = r_clk_lvl;
                // Command goes out MSB first; ~count picks bit 7 - count.
                w_mosi = w_cmd[~r_bit_cnt[2:0]];
            end
            tpsr_pkg::ST_RECV: begin
                w_cs_n = 1'b0;
                w_sck  = r_clk_lvl;
            end
            tpsr_pkg::ST_DONE: begin
                w_sv = r_axis;
            end
            default: begin
                w_busy = i_tick.start_req;
            end
        endcase
    end

    // Sequencer registers, advanced once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tpsr_pkg::ST_IDLE;
            r_axis    <= 1'b0;
            r_bit_cnt <= '0;
            r_clk_lvl <= 1'b0;
            r_shift   <= '0;
            r_raw_x   <= '1;
            r_raw_y   <= '1;
        end else if (w_accept) begin
            r_state   <= n_state;
            r_axis    <= n_axis;
            r_bit_cnt <= n_bit_cnt;
            r_clk_lvl <= n_clk_lvl;
            r_shift   <= n_shift;
            r_raw_x   <= n_raw_x;
            r_raw_y   <= n_raw_y;
        end
    end

    // Divider datapath: restoring division of the reading by the scale magnitude.
    assign w_scale_sel  = r_div_axis ? r_scale_y : r_scale_x;
    assign w_offset_sel = r_div_axis ? r_offset_y : r_offset_x;
    assign w_mag        = w_scale_sel[COEF_BITS-1] ? (~w_scale_sel + COEF_BITS'(1))
                                                   : w_scale_sel;
    assign w_trial      = {r_rem, r_dvd[COORD_BITS-1]};
    assign w_diff       = w_trial - {1'b0, w_mag};
    assign w_div_done   = r_div_run && (r_div_cnt == '0);

    // Sign the quotient, add the offset and saturate to the output range.
    assign w_q_ext = {{(SUM_W-COORD_BITS){1'b0}}, r_dvd};
    assign w_q_sgn = w_scale_sel[COEF_BITS-1] ? (~w_q_ext + SUM_W'(1)) : w_q_ext;
    assign w_sum   = w_q_sgn + {{(SUM_W-COEF_BITS){w_offset_sel[COEF_BITS-1]}}, w_offset_sel};
    assign w_fits  = (&w_sum[SUM_W-1:CAL_BITS-1]) || !(|w_sum[SUM_W-1:CAL_BITS-1]);
    assign w_sat   = w_fits ? w_sum[CAL_BITS-1:0]
                   : (w_sum[SUM_W-1] ? {1'b1, {(CAL_BITS-1){1'b0}}}
                                     : {1'b0, {(CAL_BITS-1){1'b1}}});

    // Divider control: X then Y, one quotient bit per clock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_run  <= 1'b0;
            r_div_axis <= 1'b0;
            r_div_cnt  <= '0;
        end else if (w_accept && w_cal_start) begin
            r_div_run  <= 1'b1;
            r_div_axis <= 1'b0;
            r_div_cnt  <= DIV_CW'(COORD_BITS);
        end else if (r_div_run) begin
            if (r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - DIV_CW'(1);
            end else if (!r_div_axis) begin
                r_div_axis <= 1'b1;
                r_div_cnt  <= DIV_CW'(COORD_BITS);
            end else begin
                r_div_run <= 1'b0;
            end
        end
    end

    // Divider remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (w_accept && w_cal_start) begin
            r_rem <= '0;
            r_dvd <= r_raw_x;
        end else if (r_div_run) begin
            if (r_div_cnt != '0) begin
                if (!w_diff[COEF_BITS]) begin
                    r_rem <= w_diff[COEF_BITS-1:0];
                end else begin
                    r_rem <= w_trial[COEF_BITS-1:0];
                end
                r_dvd <= {r_dvd[COORD_BITS-2:0], !w_diff[COEF_BITS]};
            end else begin
                r_rem <= '0;
                r_dvd <= r_raw_y;
            end
        end
    end

    // Held calibrated values: cleared on bad coefficients, else filled by the divider.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_x <= '0;
            r_cal_y <= '0;
        end else if (w_accept && (r_state == tpsr_pkg::ST_DONE) && r_axis && w_coef_bad) begin
            r_cal_x <= '0;
            r_cal_y <= '0;
        end else if (w_div_done) begin
            if (r_div_axis) begin
                r_cal_y <= w_sat;
            end else begin
                r_cal_x <= w_sat;
            end
        end
    end

    // Output register: filled on each tick, or when the divider finishes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_accept) begin
            r_out_vld <= !w_cal_start;
        end else if (w_div_done && r_div_axis) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_o_cs_n <= w_cs_n;
            r_o_sck  <= w_sck;
            r_o_mosi <= w_mosi;
            r_o_busy <= w_busy;
            r_o_sv   <= w_sv;
            r_o_pen  <= !i_tick.pen_irq_n;
        end
    end

    // Result fields; held raw readings change only together with the output register.
    assign o_res.valid        = r_out_vld;
    assign o_res.cs_n         = r_o_cs_n;
    assign o_res.sck          = r_o_sck;
    assign o_res.mosi         = r_o_mosi;
    assign o_res.busy_res     = r_o_busy;
    assign o_res.sample_valid = r_o_sv;
    assign o_res.raw_x        = r_raw_x;
    assign o_res.raw_y        = r_raw_y;
    assign o_res.cal_x        = r_cal_x;
    assign o_res.cal_y        = r_cal_y;
    assign o_res.coef_bad     = w_coef_bad;
    assign o_res.pen_down     = r_o_pen;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none

module tb_top;
    import tpsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W    = COORD_BITS_DEF;
    localparam int COEF_W     = COEF_BITS_DEF;
    localparam int HALF_CLK   = 6;
    localparam int RST_CYCLES = 6;
    // Pause after the last result so that a divider pass cannot still be running
    // when the block is reconfigured.
    localparam int DRAIN_PAD  = 2 * (COORD_W + 1) + 4;
    localparam int LONG_HOLD  = 400;
    localparam int STALL_MAX  = 4000;
    // Tick requests for the whole run, directed part included.
    localparam int TOTAL_TICKS = 1350;
    localparam int MIN_PHASES  = 2;
    localparam int MAX_PRINTS = 40;

    // One expected or observed result request.
    typedef struct {
        logic               cs_n;
        logic               sck;
        logic               mosi;
        logic               busy;
        logic               smp_valid;
        logic [COORD_W-1:0] raw_x;
        logic [COORD_W-1:0] raw_y;
        logic [CAL_BITS-1:0] cal_x;
        logic [CAL_BITS-1:0] cal_y;
        logic               coef_bad;
        logic               pen_down;
    } tick_res_t;

    // Tracks the sequencer and the calibration registers and holds the results that
    // the accepted tick requests should produce, oldest first.
    class panel_tick_tracker;
        t_seq_state          seq;
        logic                axis;
        logic [4:0]          bit_cnt;
        logic                clk_lvl;
        logic [15:0]         shreg;
        logic [COORD_W-1:0]  hraw_x;
        logic [COORD_W-1:0]  hraw_y;
        logic [CAL_BITS-1:0] hcal_x;
        logic [CAL_BITS-1:0] hcal_y;
        logic [COEF_W-1:0]   regs [4];
        tick_res_t           expected_ticks [$];
        int                  errors;
        int                  n_results;

        function new();
            seq       = ST_IDLE;
            axis      = 1'b0;
            bit_cnt   = '0;
            clk_lvl   = 1'b0;
            shreg     = '0;
            hraw_x    = '1;
            hraw_y    = '1;
            hcal_x    = '0;
            hcal_y    = '0;
            regs[CFG_SCALE_X]  = 1;
            regs[CFG_OFFSET_X] = 0;
            regs[CFG_SCALE_Y]  = 1;
            regs[CFG_OFFSET_Y] = 0;
            errors    = 0;
            n_results = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [COEF_W-1:0] val);
            regs[idx] = val;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function bit seq_idle();
            return seq == ST_IDLE;
        endfunction

        // A zero divisor or any register at all ones makes the coefficients unusable.
        function bit coefs_bad();
            return regs[CFG_SCALE_X] == '0 || regs[CFG_SCALE_Y] == '0 ||
                   regs[CFG_SCALE_X] == '1 || regs[CFG_OFFSET_X] == '1 ||
                   regs[CFG_SCALE_Y] == '1 || regs[CFG_OFFSET_Y] == '1;
        endfunction

        // Quotient truncated toward zero, plus offset, clamped to the signed 16-bit range.
        function logic [CAL_BITS-1:0] calibrate(logic [COORD_W-1:0] raw,
                                                logic [COEF_W-1:0] sc,
                                                logic [COEF_W-1:0] off);
            longint q;
            longint t;
            q = longint'(raw) / longint'($signed(sc));
            t = q + longint'($signed(off));
            if (t > 32767) begin
                t = 32767;
            end
            if (t < -32768) begin
                t = -32768;
            end
            return t[CAL_BITS-1:0];
        endfunction

        function void store_raw(logic [COORD_W-1:0] v);
            if (!axis) begin
                hraw_x = v;
            end else begin
                hraw_y = v;
            end
        endfunction

        // Advance the sequencer by one accepted tick request and queue its result.
        function void note_tick(logic start, logic pen_n, logic miso);
            tick_res_t r;
            logic [CMD_BITS-1:0] cmd;
            r.cs_n      = 1'b1;
            r.sck       = 1'b0;
            r.mosi      = 1'b0;
            r.busy      = 1'b1;
            r.smp_valid = 1'b0;
            case (seq)
                ST_SELECT: begin
                    // The pen line counts only here, once per axis.
                    if (pen_n) begin
                        store_raw('1);
                        seq = ST_DONE;
                    end else begin
                        r.cs_n  = 1'b0;
                        bit_cnt = '0;
                        clk_lvl = 1'b0;
                        seq     = ST_CMD;
                    end
                end
                ST_CMD: begin
                    r.cs_n = 1'b0;
                    cmd    = axis ? CMD_Y : CMD_X;
                    r.mosi = cmd[3'd7 - bit_cnt[2:0]];
                    if (!clk_lvl) begin
                        clk_lvl = 1'b1;
                    end else begin
                        r.sck   = 1'b1;
                        clk_lvl = 1'b0;
                        bit_cnt = bit_cnt + 5'd1;
                        if (bit_cnt >= CMD_BITS) begin
                            bit_cnt = '0;
                            shreg   = '0;
                            seq     = ST_RECV;
                        end
                    end
                end
                ST_RECV: begin
                    r.cs_n = 1'b0;
                    if (!clk_lvl) begin
                        clk_lvl = 1'b1;
                    end else begin
                        r.sck   = 1'b1;
                        clk_lvl = 1'b0;
                        shreg   = {shreg[14:0], miso};
                        bit_cnt = bit_cnt + 5'd1;
                        if (bit_cnt >= RX_BITS) begin
                            bit_cnt = '0;
                            store_raw(shreg[15 -: COORD_W]);
                            seq = ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!axis) begin
                        axis = 1'b1;
                        seq  = ST_SELECT;
                    end else begin
                        if (coefs_bad()) begin
                            hcal_x = '0;
                            hcal_y = '0;
                        end else begin
                            hcal_x = calibrate(hraw_x, regs[CFG_SCALE_X], regs[CFG_OFFSET_X]);
                            hcal_y = calibrate(hraw_y, regs[CFG_SCALE_Y], regs[CFG_OFFSET_Y]);
                        end
                        r.smp_valid = 1'b1;
                        axis = 1'b0;
                        seq  = ST_IDLE;
                    end
                end
                default: begin
                    // A start request is honored only here; elsewhere it is ignored.
                    seq = ST_IDLE;
                    if (start) begin
                        axis    = 1'b0;
                        bit_cnt = '0;
                        clk_lvl = 1'b0;
                        seq     = ST_SELECT;
                    end else begin
                        r.busy = 1'b0;
                    end
                end
            endcase
            r.raw_x    = hraw_x;
            r.raw_y    = hraw_y;
            r.cal_x    = hcal_x;
            r.cal_y    = hcal_y;
            r.coef_bad = coefs_bad();
            r.pen_down = !pen_n;
            expected_ticks.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS) begin
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        task cmp_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 n_results, name, got, want));
            end
        endtask

        // Compare one accepted result request against the oldest expectation.
        task check_tick_result(tick_res_t got);
            tick_res_t want;
            if (expected_ticks.size() == 0) begin
                report("result request arrived with no tick request pending");
                return;
            end
            want = expected_ticks.pop_front();
            n_results++;
            cmp_field("cs_n", got.cs_n, want.cs_n);
            cmp_field("sck", got.sck, want.sck);
            cmp_field("mosi", got.mosi, want.mosi);
            cmp_field("busy_res", got.busy, want.busy);
            cmp_field("sample_valid", got.smp_valid, want.smp_valid);
            cmp_field("raw_x", got.raw_x, want.raw_x);
            cmp_field("raw_y", got.raw_y, want.raw_y);
            cmp_field("cal_x", got.cal_x, want.cal_x);
            cmp_field("cal_y", got.cal_y, want.cal_y);
            cmp_field("coef_bad", got.coef_bad, want.coef_bad);
            cmp_field("pen_down", got.pen_down, want.pen_down);
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [COEF_W-1:0]       i_cfg_data;

    tpsr_in_if                           tick_if ();
    tpsr_out_if #(.COORD_BITS(COORD_W)) res_if ();

    panel_tick_tracker tracker;
    int                hold_reqs;
    int                stall_cycles;
    int                ticks_sent;
    int                burst_left;

    touch_panel_serial_reader_unit #(
        .COORD_BITS(COORD_W),
        .COEF_BITS (COEF_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_tick    (tick_if),
        .o_res     (res_if)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
    end
    always #HALF_CLK i_clk = ~i_clk;

    // Monitor: check results, track accepted ticks and register writes, watch for hangs.
    always @(posedge i_clk) begin
        tick_res_t got;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                got.cs_n      = res_if.cs_n;
                got.sck       = res_if.sck;
                got.mosi      = res_if.mosi;
                got.busy      = res_if.busy_res;
                got.smp_valid = res_if.sample_valid;
                got.raw_x     = res_if.raw_x;
                got.raw_y     = res_if.raw_y;
                got.cal_x     = res_if.cal_x;
                got.cal_y     = res_if.cal_y;
                got.coef_bad  = res_if.coef_bad;
                got.pen_down  = res_if.pen_down;
                tracker.check_tick_result(got);
            end
            if (tick_if.valid && tick_if.ready) begin
                tracker.note_tick(tick_if.start_req, tick_if.pen_irq_n, tick_if.miso);
            end
            if (i_cfg_we) begin
                tracker.write_reg(t_cfg_idx'(i_cfg_idx), i_cfg_data);
            end
            if ((res_if.valid && res_if.ready) || (tick_if.valid && tick_if.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_MAX) begin
                $display("watchdog: no request moved for %0d cycles", STALL_MAX);
                $display("** touch_panel_serial_reader_unit: FAILED **");
                $finish;
            end
        end
    end

    // Receiver: changing stall patterns, plus a long hold-off whenever one is requested.
    initial begin
        int mode;
        int mode_left;
        int hold_left;
        int holds_seen;
        int pat;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        holds_seen = 0;
        pat        = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_seen != hold_reqs) begin
                holds_seen = hold_reqs;
                hold_left  = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            pat++;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= ($urandom_range(0, 9) < 7);
                    2: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default: res_if.ready <= (pat % 5 != 0) && (pat % 7 != 3);
                endcase
            end
        end
    end

    // Offer one tick request and wait until it is taken. The sender works in bursts
    // separated by random gaps; some gaps are zero so that stretches run back to back.
    task send_tick(logic start, logic pen_n, logic miso);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                tick_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        tick_if.valid     <= 1'b1;
        tick_if.start_req <= start;
        tick_if.pen_irq_n <= pen_n;
        tick_if.miso      <= miso;
        do @(posedge i_clk); while (!tick_if.ready);
        ticks_sent++;
    endtask

    // Stop offering and wait until every expected result request has arrived.
    task wait_drained();
        tick_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    // Drain, then feed ticks without a start until the sequencer is back at rest.
    task settle();
        wait_drained();
        while (!tracker.seq_idle()) begin
            send_tick(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            wait_drained();
        end
    endtask

    task program_regs(logic [COEF_W-1:0] sx, logic [COEF_W-1:0] ox,
                      logic [COEF_W-1:0] sy, logic [COEF_W-1:0] oy);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SCALE_X;
        i_cfg_data <= sx;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFFSET_X;
        i_cfg_data <= ox;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SCALE_Y;
        i_cfg_data <= sy;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_OFFSET_Y;
        i_cfg_data <= oy;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // One X-then-Y sample laid out tick by tick. The pen level lands on each axis's
    // select tick; start_noise raises start on busy ticks and pen_noise wiggles the pen
    // line during transfers. A nonzero cut truncates the sequence, and the sender
    // drains all results once at tick pause_at.
    task run_sample(logic xpn, logic ypn, int miso_mode, bit start_noise,
                    bit pen_noise, int cut, int pause_at);
        int   n;
        int   ysel;
        logic s;
        logic p;
        logic m;
        ysel = 3 + (xpn ? 0 : 2 * (CMD_BITS + RX_BITS));
        n    = ysel + 2 + (ypn ? 0 : 2 * (CMD_BITS + RX_BITS));
        if (cut > 0 && cut < n) begin
            n = cut;
        end
        for (int i = 0; i < n; i++) begin
            s = (i == 0) ? 1'b1 : (start_noise ? 1'($urandom_range(0, 1)) : 1'b0);
            if (i == 1) begin
                p = xpn;
            end else if (i == ysel) begin
                p = ypn;
            end else if (pen_noise) begin
                p = 1'($urandom_range(0, 1));
            end else begin
                p = (i < ysel) ? xpn : ypn;
            end
            case (miso_mode)
                0: m = 1'($urandom_range(0, 1));
                1: m = 1'b1;
                2: m = 1'b0;
                default: m = 1'(i % 2);
            endcase
            send_tick(s, p, m);
            if (i == pause_at) begin
                wait_drained();
            end
        end
    endtask

    // Coefficient picker weighted toward the extremes, with occasional bad values.
    function logic [COEF_W-1:0] pick_coef(bit is_scale);
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0: return 16'h0001;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3, 4: return COEF_W'($urandom_range(1, 20));
            5: return -COEF_W'($urandom_range(2, 20));
            12: return is_scale ? 16'h0000 : COEF_W'($urandom_range(0, 100));
            13: return 16'hFFFF;
            default: return COEF_W'($urandom);
        endcase
    endfunction

    // Stimulus and end of run.
    initial begin
        int phase;
        int segs;
        int kind;
        tracker      = new();
        hold_reqs    = 0;
        stall_cycles = 0;
        ticks_sent   = 0;
        burst_left   = 0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= CFG_SCALE_X;
        i_cfg_data        <= '0;
        tick_if.valid     <= 1'b0;
        tick_if.start_req <= 1'b0;
        tick_if.pen_irq_n <= 1'b1;
        tick_if.miso      <= 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: idle ticks, data extremes, pen up, pen changes mid-transfer,
        // start while busy and a truncated sequence, all with reset coefficients.
        send_tick(1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1);
        run_sample(1'b0, 1'b0, 1, 0, 0, 0, -1);
        run_sample(1'b0, 1'b0, 2, 0, 0, 0, -1);
        run_sample(1'b1, 1'b1, 0, 0, 0, 0, -1);
        run_sample(1'b1, 1'b0, 3, 1, 1, 0, -1);
        run_sample(1'b0, 1'b1, 0, 1, 1, 0, -1);
        run_sample(1'b0, 1'b0, 0, 0, 0, 20, -1);
        settle();

        // Directed: bad coefficients, then extreme scales and saturation both ways.
        program_regs(16'h0000, 16'h0005, 16'h0003, 16'h0000);
        run_sample(1'b0, 1'b0, 1, 0, 0, 0, -1);
        program_regs(16'h0001, 16'h0000, 16'h0001, 16'hFFFF);
        run_sample(1'b0, 1'b0, 1, 0, 0, 0, -1);
        program_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        run_sample(1'b0, 1'b0, 1, 0, 0, 0, -1);
        program_regs(16'h0001, 16'h7FFF, 16'hFFFE, 16'h8000);
        run_sample(1'b0, 1'b0, 1, 0, 0, 0, -1);
        program_regs(16'h0001, 16'h0000, 16'h0001, 16'h0000);

        // Random phases: new coefficients each phase, mostly well-formed samples,
        // some noise and broken sequences. The second phase always runs so that the
        // long receiver hold-off takes place.
        phase = 0;
        while (ticks_sent < TOTAL_TICKS || phase < MIN_PHASES) begin
            program_regs(pick_coef(1), pick_coef(0), pick_coef(1), pick_coef(0));
            segs = $urandom_range(3, 8);
            for (int k = 0; k < segs; k++) begin
                if (phase == 1 && k == 0) begin
                    // The receiver holds off while the sender keeps offering.
                    hold_reqs++;
                end
                kind = $urandom_range(0, 99);
                if (kind < 80) begin
                    run_sample(($urandom_range(0, 9) < 3), ($urandom_range(0, 9) < 3),
                               $urandom_range(0, 3), ($urandom_range(0, 3) == 0),
                               ($urandom_range(0, 1) == 1), 0,
                               (phase == 2 && k == 0) ? 30 : -1);
                end else if (kind < 92) begin
                    repeat ($urandom_range(1, 20)) begin
                        send_tick(($urandom_range(0, 9) == 0), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    end
                    settle();
                end else begin
                    run_sample(1'b0, 1'($urandom_range(0, 1)), 0, 1, 1,
                               $urandom_range(2, 100), -1);
                    settle();
                end
            end
            phase++;
        end

        settle();
        repeat (DRAIN_PAD) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("** touch_panel_serial_reader_unit: PASSED **");
        end else begin
            $display("** touch_panel_serial_reader_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
